@@ hdl/bhpq_pkg.sv @@
// shared types and constants for the binary heap priority queue
package bhpq_pkg;

   localparam int unsigned VAL_W = 32;
   localparam int unsigned CNT_W = 11;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PEEK   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CSR_ORDER    = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RDL,
      S_DN_RDR,
      S_DN_CMP,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;      // latch request fields
      logic ins_write;   // write new value at count, bump count
      logic rem_start;   // capture top, move last to root, drop count
      logic clear;
      logic up_rd;       // read parent of cursor
      logic up_swap;     // move parent down to cursor, cursor to parent
      logic dn_rdl;      // read left child
      logic dn_rdr;      // read right child
      logic dn_swap;     // move chosen child up to cursor, cursor to child
      logic settle;      // write the moving value at the cursor
      logic respond;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic up_better;   // cursor strictly better than parent
      logic has_left;
      logic has_right;
      logic dn_better;   // chosen child strictly better than cursor
   } stat_type;

   // strict precedence: a above b
   function automatic logic better(input logic signed [VAL_W-1:0] a,
                                   input logic signed [VAL_W-1:0] b,
                                   input logic order);
      return order ? (a < b) : (a > b);
   endfunction

endpackage

@@ hdl/bhpq_ctrl.sv @@
// controller state machine for the heap queue
module bhpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  bhpq_pkg::op_type   op,
   input  bhpq_pkg::stat_type stat,
   output logic               busy,
   output bhpq_pkg::cmd_type  cmd
);

   bhpq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhpq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != bhpq_pkg::S_IDLE);
      case (state_ff)
         bhpq_pkg::S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               case (op)
                  bhpq_pkg::OP_INSERT: begin
                     if (stat.full) begin
                        state_in = bhpq_pkg::S_DONE;
                     end else begin
                        cmd.ins_write = 1'b1;
                        state_in = bhpq_pkg::S_UP_RD;
                     end
                  end
                  bhpq_pkg::OP_REMOVE: begin
                     if (stat.empty) begin
                        state_in = bhpq_pkg::S_DONE;
                     end else begin
                        cmd.rem_start = 1'b1;
                        state_in = bhpq_pkg::S_DN_RDL;
                     end
                  end
                  bhpq_pkg::OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in = bhpq_pkg::S_DONE;
                  end
                  default: state_in = bhpq_pkg::S_DONE;
               endcase
            end
         end
         bhpq_pkg::S_UP_RD: begin
            if (stat.at_root) begin
               cmd.settle = 1'b1;
               state_in = bhpq_pkg::S_DONE;
            end else begin
               cmd.up_rd = 1'b1;
               state_in = bhpq_pkg::S_UP_CMP;
            end
         end
         bhpq_pkg::S_UP_CMP: begin
            if (stat.up_better) begin
               cmd.up_swap = 1'b1;
               state_in = bhpq_pkg::S_UP_RD;
            end else begin
               cmd.settle = 1'b1;
               state_in = bhpq_pkg::S_DONE;
            end
         end
         bhpq_pkg::S_DN_RDL: begin
            if (!stat.has_left) begin
               cmd.settle = 1'b1;
               state_in = bhpq_pkg::S_DONE;
            end else begin
               cmd.dn_rdl = 1'b1;
               state_in = bhpq_pkg::S_DN_RDR;
            end
         end
         bhpq_pkg::S_DN_RDR: begin
            cmd.dn_rdr = stat.has_right;
            state_in = bhpq_pkg::S_DN_CMP;
         end
         bhpq_pkg::S_DN_CMP: begin
            if (stat.dn_better) begin
               cmd.dn_swap = 1'b1;
               state_in = bhpq_pkg::S_DN_RDL;
            end else begin
               cmd.settle = 1'b1;
               state_in = bhpq_pkg::S_DONE;
            end
         end
         bhpq_pkg::S_DONE: begin
            cmd.respond = 1'b1;
            state_in = bhpq_pkg::S_IDLE;
         end
         default: state_in = bhpq_pkg::S_IDLE;
      endcase
   end

endmodule

@@ hdl/bhpq_dp.sv @@
// datapath: heap memory, cursor, count and comparators
module bhpq_dp #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bhpq_pkg::cmd_type               cmd,
   input  bhpq_pkg::op_type                op,
   input  logic signed [bhpq_pkg::VAL_W-1:0] value,
   input  logic                            order,
   input  logic [bhpq_pkg::CNT_W-1:0]      cap_limit,
   output bhpq_pkg::stat_type              stat,
   output logic                            rsp_strobe,
   output bhpq_pkg::status_type            rsp_status,
   output logic signed [bhpq_pkg::VAL_W-1:0] rsp_top_value,
   output logic [bhpq_pkg::CNT_W-1:0]      rsp_count
);

   localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW  = $clog2(DEPTH + 1);
   localparam int unsigned XW  = CW + 1;

   logic signed [bhpq_pkg::VAL_W-1:0] mem [DEPTH];

   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     cur_ff;      // cursor index
   logic signed [bhpq_pkg::VAL_W-1:0] cur_val_ff;  // value held at cursor
   logic signed [bhpq_pkg::VAL_W-1:0] rd_ff;       // parent or left child
   logic signed [bhpq_pkg::VAL_W-1:0] rdr_ff;      // right child
   logic                              use_r_ff;
   logic signed [bhpq_pkg::VAL_W-1:0] top_ff;
   bhpq_pkg::status_type              status_ff;
   logic                              strobe_ff;

   logic [CW-1:0]  parent;
   logic [XW-1:0]  left_x, right_x;
   logic [CW-1:0]  cap_eff;
   logic           pick_r;
   logic signed [bhpq_pkg::VAL_W-1:0] child_val;
   logic [CW-1:0]  child_idx;
   logic [CW-1:0]  last_idx;

   assign parent   = (cur_ff - CW'(1)) >> 1;
   assign left_x   = {cur_ff, 1'b1};
   assign right_x  = left_x + XW'(1);
   assign last_idx = count_ff - CW'(1);
   assign cap_eff  = (32'(cap_limit) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cap_limit);
   assign pick_r   = use_r_ff && bhpq_pkg::better(rdr_ff, rd_ff, order);
   assign child_val = pick_r ? rdr_ff : rd_ff;
   assign child_idx = pick_r ? right_x[CW-1:0] : left_x[CW-1:0];

   always_comb begin
      stat           = '0;
      stat.full      = (count_ff >= cap_eff);
      stat.empty     = (count_ff == '0);
      stat.at_root   = (cur_ff == '0);
      stat.up_better = bhpq_pkg::better(cur_val_ff, rd_ff, order);
      stat.has_left  = (left_x < XW'(count_ff));
      stat.has_right = (right_x < XW'(count_ff));
      stat.dn_better = bhpq_pkg::better(child_val, cur_val_ff, order);
   end

   // single write port, registered reads
   // the moving value of either sift lives in cur_val_ff; apart from the insert
   // write at count, it is written only where it settles
   always_ff @(posedge clock) begin
      if (cmd.ins_write) begin
         mem[count_ff[AW-1:0]] <= value;
      end else if (cmd.up_swap) begin
         mem[cur_ff[AW-1:0]] <= rd_ff;
      end else if (cmd.dn_swap) begin
         mem[cur_ff[AW-1:0]] <= child_val;
      end else if (cmd.settle) begin
         mem[cur_ff[AW-1:0]] <= cur_val_ff;
      end
      if (cmd.up_rd) begin
         rd_ff <= mem[parent[AW-1:0]];
      end else if (cmd.dn_rdl) begin
         rd_ff <= mem[left_x[AW-1:0]];
      end
      if (cmd.dn_rdr) begin
         rdr_ff <= mem[right_x[AW-1:0]];
      end
      if (cmd.rem_start) begin
         top_ff     <= mem[0];
         cur_val_ff <= mem[last_idx[AW-1:0]];
      end else if (cmd.ins_write) begin
         cur_val_ff <= value;
      end
   end

   // peek in progress: the top value comes from the root snapshot
   logic dn_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cur_ff     <= '0;
         use_r_ff   <= 1'b0;
         status_ff  <= bhpq_pkg::ST_OK;
         strobe_ff  <= 1'b0;
         dn_hold_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
         if (cmd.accept) begin
            if ((op == bhpq_pkg::OP_INSERT) && stat.full) begin
               status_ff <= bhpq_pkg::ST_FULL;
            end else if (((op == bhpq_pkg::OP_REMOVE) || (op == bhpq_pkg::OP_PEEK))
                         && stat.empty) begin
               status_ff <= bhpq_pkg::ST_EMPTY;
            end else begin
               status_ff <= bhpq_pkg::ST_OK;
            end
            if ((op == bhpq_pkg::OP_PEEK) && !stat.empty) begin
               dn_hold_ff <= 1'b1;
            end else begin
               dn_hold_ff <= 1'b0;
            end
         end
         if (cmd.ins_write) begin
            cur_ff   <= count_ff;
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.rem_start) begin
            cur_ff   <= '0;
            count_ff <= last_idx;
         end
         if (cmd.clear) begin
            count_ff <= '0;
         end
         if (cmd.up_swap) begin
            cur_ff <= parent;
         end
         if (cmd.dn_rdr || cmd.dn_rdl) begin
            use_r_ff <= cmd.dn_rdr;
         end
         if (cmd.dn_swap) begin
            cur_ff <= child_idx;
         end
      end
   end

   logic signed [bhpq_pkg::VAL_W-1:0] peek_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         peek_ff <= mem[0];
      end
   end

   logic [bhpq_pkg::CNT_W-1:0] cnt_out;
   assign cnt_out = bhpq_pkg::CNT_W'(count_ff);

   logic rem_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rem_ff <= (op == bhpq_pkg::OP_REMOVE);
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_top_value = (status_ff != bhpq_pkg::ST_OK) ? '0 :
                          rem_ff ? top_ff : (dn_hold_ff ? peek_ff : '0);
   assign rsp_count     = cnt_out;

endmodule

@@ hdl/binary_heap_priority_queue_core.sv @@
// top level of the binary heap priority queue
//
// channel   dir  handshake                 payload
// req       in   start & !busy             req_op, req_value
// rsp       out  rsp_valid, one cycle      rsp_status, rsp_top_value, rsp_count
// csr       in   csr_valid & csr_ready     csr_index, csr_data
//
// steps from the accepting edge to the edge that takes the result:
// peek, clear and refused requests go from idle straight to done
// insert: a parent read and a compare per level climbed, then the settle write
// remove: left read, right read and compare per level descended, then settle
// reset clears count, order (max-heap) and capacity (1024); memory is not cleared
// busy drops while the result shows, so the next request may be taken at the
// edge that takes the result; the result cannot be stalled
module binary_heap_priority_queue_core #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_op,
   input  logic signed [bhpq_pkg::VAL_W-1:0]   req_value,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic signed [bhpq_pkg::VAL_W-1:0]   rsp_top_value,
   output logic [bhpq_pkg::CNT_W-1:0]          rsp_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [bhpq_pkg::CNT_W-1:0]          csr_data
);

   bhpq_pkg::cmd_type    cmd;
   bhpq_pkg::stat_type   stat;
   bhpq_pkg::status_type status;
   bhpq_pkg::op_type     op;

   logic                       order_ff;
   logic [bhpq_pkg::CNT_W-1:0] cap_ff;

   assign op        = bhpq_pkg::op_type'(req_op);
   assign csr_ready = 1'b1;

   // configuration beats
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         cap_ff   <= bhpq_pkg::CNT_W'(1024);
      end else if (csr_valid && csr_ready) begin
         case (bhpq_pkg::csr_idx_type'(csr_index))
            bhpq_pkg::CSR_ORDER:    order_ff <= csr_data[0];
            bhpq_pkg::CSR_CAPACITY: cap_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   bhpq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (op),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   bhpq_dp #(.DEPTH(DEPTH)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .op            (op),
      .value         (req_value),
      .order         (order_ff),
      .cap_limit     (cap_ff),
      .stat          (stat),
      .rsp_strobe    (rsp_valid),
      .rsp_status    (status),
      .rsp_top_value (rsp_top_value),
      .rsp_count     (rsp_count)
   );

   assign rsp_status = status;

endmodule

@@ hdl/bhpq_checker.sv @@
// port-level checks for the heap queue core
module bhpq_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [1:0]                 rsp_status,
   input logic signed [31:0]         rsp_top_value,
   input logic [10:0]                rsp_count
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not raise busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result longer than one beat");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while result shows");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bhpq_pkg::ST_OK) |-> (rsp_top_value == 32'sd0))
      else $error("refused result carries a value");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bhpq_pkg::ST_EMPTY) |-> (rsp_count == 11'd0))
      else $error("empty status with nonzero count");

endmodule

bind binary_heap_priority_queue_core bhpq_checker u_bhpq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_top_value (rsp_top_value),
   .rsp_count     (rsp_count)
);

@@ tb/heap_checker.sv @@
// checker for the heap queue: watches req, rsp and csr, predicts and compares results
`timescale 1ns / 1ps
module heap_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_op,
   input  logic signed [bhpq_pkg::VAL_W-1:0] req_value,
   input  logic                              rsp_valid,
   input  logic [1:0]                        rsp_status,
   input  logic signed [bhpq_pkg::VAL_W-1:0] rsp_top_value,
   input  logic [bhpq_pkg::CNT_W-1:0]        rsp_count,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [bhpq_pkg::CNT_W-1:0]        csr_data,
   output int                                fail_count,
   output int                                pending
);

   localparam int DEPTH = 1024;

   typedef struct packed {
      logic [1:0]                        status;
      logic signed [bhpq_pkg::VAL_W-1:0] top_value;
      logic [bhpq_pkg::CNT_W-1:0]        count;
   } answer_type;

   logic signed [bhpq_pkg::VAL_W-1:0] shadow_heap [DEPTH];
   int         shadow_count;
   logic       shadow_min_first;
   int         shadow_cap;
   answer_type answers_due [$];

   // strict precedence of a over b under the current order
   function automatic bit ranks_above(logic signed [bhpq_pkg::VAL_W-1:0] a,
                                      logic signed [bhpq_pkg::VAL_W-1:0] b);
      return shadow_min_first ? (a < b) : (a > b);
   endfunction

   task automatic exchange(int i, int j);
      logic signed [bhpq_pkg::VAL_W-1:0] t;
      t = shadow_heap[i];
      shadow_heap[i] = shadow_heap[j];
      shadow_heap[j] = t;
   endtask

   task automatic apply_request(bhpq_pkg::op_type op, logic signed [bhpq_pkg::VAL_W-1:0] v);
      answer_type a;
      int i, p, l, r, c, cap;
      a.status = bhpq_pkg::ST_OK;
      a.top_value = '0;
      cap = shadow_cap > DEPTH ? DEPTH : shadow_cap;
      case (op)
         bhpq_pkg::OP_INSERT: begin
            if (shadow_count >= cap) a.status = bhpq_pkg::ST_FULL;
            else begin
               shadow_heap[shadow_count] = v;
               i = shadow_count;
               shadow_count++;
               while (i > 0) begin
                  p = (i - 1) / 2;
                  if (!ranks_above(shadow_heap[i], shadow_heap[p])) break;
                  exchange(i, p);
                  i = p;
               end
            end
         end
         bhpq_pkg::OP_REMOVE: begin
            if (shadow_count == 0) a.status = bhpq_pkg::ST_EMPTY;
            else begin
               a.top_value = shadow_heap[0];
               shadow_count--;
               shadow_heap[0] = shadow_heap[shadow_count];
               i = 0;
               forever begin
                  l = 2 * i + 1;
                  r = l + 1;
                  if (l >= shadow_count) break;
                  c = l;
                  if (r < shadow_count && ranks_above(shadow_heap[r], shadow_heap[l])) c = r;
                  if (!ranks_above(shadow_heap[c], shadow_heap[i])) break;
                  exchange(i, c);
                  i = c;
               end
            end
         end
         bhpq_pkg::OP_PEEK: begin
            if (shadow_count == 0) a.status = bhpq_pkg::ST_EMPTY;
            else a.top_value = shadow_heap[0];
         end
         default: shadow_count = 0;
      endcase
      a.count = shadow_count[bhpq_pkg::CNT_W-1:0];
      answers_due.push_back(a);
   endtask

   assign pending = answers_due.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         shadow_count = 0;
         shadow_min_first = 1'b0;
         shadow_cap = 1024;
         answers_due.delete();
         fail_count <= 0;
      end else begin
         // a result leaves before any new beat can be predicted
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result status %0d top %0d count %0d",
                        $time, rsp_status, rsp_top_value, rsp_count);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (want.status !== rsp_status || want.top_value !== rsp_top_value
                   || want.count !== rsp_count) begin
                  $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d",
                           $time, want.status, want.top_value, want.count,
                           rsp_status, rsp_top_value, rsp_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) apply_request(bhpq_pkg::op_type'(req_op), req_value);
         if (csr_valid && csr_ready) begin
            if (csr_index == bhpq_pkg::CSR_ORDER) shadow_min_first = csr_data[0];
            else shadow_cap = csr_data;
         end
      end
   end

endmodule

@@ tb/testbench.sv @@
// stimulus and verdict for the binary heap priority queue core
`timescale 1ns / 1ps
module testbench;

   logic clock, reset, start, busy, rsp_valid, csr_valid, csr_ready, csr_index;
   logic [1:0] req_op, rsp_status;
   logic signed [bhpq_pkg::VAL_W-1:0] req_value, rsp_top_value;
   logic [bhpq_pkg::CNT_W-1:0] rsp_count, csr_data;
   int fail_count, pending;
   int gap_pct;

   binary_heap_priority_queue_core uut (.*);

   heap_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // generous cap on run time, covering the worst remove plus gaps
   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   // one request beat, with an optional random gap in front; busy read just
   // after an edge is the value that edge saw
   task automatic send(bhpq_pkg::op_type op, logic signed [bhpq_pkg::VAL_W-1:0] v);
      while ($urandom_range(99) < gap_pct) @(posedge clock);
      start <= 1'b1;
      req_op <= op;
      req_value <= v;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      // wait for the edge that takes the result
      do @(posedge clock); while (busy);
   endtask

   // registers change only with nothing in flight
   task automatic write_reg(bhpq_pkg::csr_idx_type idx, logic [bhpq_pkg::CNT_W-1:0] d);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [bhpq_pkg::VAL_W-1:0] rand_value();
      case ($urandom_range(3))
         0: return $urandom_range(15) - 8;       // dense values give ties
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   // random traffic biased by insert share; the rest splits into removes, peeks and clears
   task automatic random_phase(int items, int insert_pct);
      int n;
      int roll;
      for (n = 0; n < items; n++) begin
         roll = $urandom_range(99);
         if (roll < insert_pct) send(bhpq_pkg::OP_INSERT, rand_value());
         else if (roll < 90) send(bhpq_pkg::OP_REMOVE, $urandom);
         else if (roll < 97) send(bhpq_pkg::OP_PEEK, $urandom);
         else send(bhpq_pkg::OP_CLEAR, $urandom);
      end
   endtask

   initial begin
      int k;
      start = 1'b0; req_op = bhpq_pkg::OP_INSERT; req_value = '0;
      csr_valid = 1'b0; csr_index = bhpq_pkg::CSR_ORDER; csr_data = '0;
      gap_pct = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, extremes, ties, capacity
      send(bhpq_pkg::OP_REMOVE, 0);
      send(bhpq_pkg::OP_PEEK, 0);
      send(bhpq_pkg::OP_INSERT, 32'sh7fffffff);
      send(bhpq_pkg::OP_INSERT, 32'sh80000000);
      send(bhpq_pkg::OP_INSERT, 0);
      send(bhpq_pkg::OP_INSERT, 0);
      send(bhpq_pkg::OP_INSERT, -1);
      send(bhpq_pkg::OP_PEEK, 32'shffffffff);
      send(bhpq_pkg::OP_REMOVE, 0);
      send(bhpq_pkg::OP_REMOVE, 0);
      send(bhpq_pkg::OP_CLEAR, 0);
      send(bhpq_pkg::OP_PEEK, 0);
      write_reg(bhpq_pkg::CSR_CAPACITY, 11'd1);
      send(bhpq_pkg::OP_INSERT, 5);
      send(bhpq_pkg::OP_INSERT, 6);
      write_reg(bhpq_pkg::CSR_CAPACITY, 11'd0);
      send(bhpq_pkg::OP_INSERT, 7);
      send(bhpq_pkg::OP_REMOVE, 0);
      write_reg(bhpq_pkg::CSR_ORDER, 11'd1);
      write_reg(bhpq_pkg::CSR_CAPACITY, 11'h7ff);
      for (k = 0; k < 6; k++) send(bhpq_pkg::OP_INSERT, 3 - k);
      send(bhpq_pkg::OP_REMOVE, 0);

      // random phases over several settings, gaps as required
      gap_pct = 36;
      random_phase(150, 60);
      write_reg(bhpq_pkg::CSR_ORDER, 11'd0);
      write_reg(bhpq_pkg::CSR_CAPACITY, 11'd1024);
      gap_pct = 84;
      random_phase(150, 55);
      write_reg(bhpq_pkg::CSR_CAPACITY, 11'd5);
      gap_pct = 0;
      random_phase(120, 55);
      write_reg(bhpq_pkg::CSR_ORDER, 11'd1);
      write_reg(bhpq_pkg::CSR_CAPACITY, 11'd1024);
      random_phase(180, 75);   // builds a deep heap
      for (k = 0; k < 12; k++) send(bhpq_pkg::OP_REMOVE, 0);

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
